// ===== hw/rtl/hdmtl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hdmtl_pkg
// Shared types and constants for the host-managed memory decoder lookup:
// beat payloads, the stored decoder entry and the fixed address geometry.
// ----------------------------------------------------------------------------
package hdmtl_pkg;

  // Default number of decoder slots.
  localparam int NumDecodersDef = 8;

  // Decoder base and size are kept in 256 MiB units, that is address bits 63..28.
  localparam int UnitShift = 28;
  // The smallest interleave granularity is 256 bytes.
  localparam int GranBaseShift = 8;
  // Width of one port number inside the port list.
  localparam int PortW = 8;

  // Reset value of the active decoder count register.
  localparam logic [3:0] ActiveReset = 4'd1;

  // Item mode codes.
  localparam logic ModeLookup = 1'b0;
  localparam logic ModeWrite  = 1'b1;

  // Input beat.
  typedef struct packed {
    logic        mode;
    logic [2:0]  slot;
    logic [63:0] address;
    logic [35:0] window_base;
    logic [35:0] window_size;
    logic [2:0]  gran_code;
    logic [1:0]  ways_code;
    logic        committed;
    logic [63:0] port_list;
  } item_t;

  // Result beat.
  typedef struct packed {
    logic             hit;
    logic [PortW-1:0] target_port;
  } result_t;

  // One decoder slot as held in the table memory.
  typedef struct packed {
    logic [35:0] base;
    logic [35:0] size;
    logic [2:0]  gran;
    logic [1:0]  ways;
    logic        committed;
    logic [63:0] ports;
  } dec_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hdm_decoder_target_lookup.sv =====
`default_nettype none
// A decoder write leaves busy low, and the next beat may follow at once.
// A lookup scans the active slots and raises done on the first match or after the last;
// with an active count of zero, done follows in the next cycle.
// The scan reads one slot per cycle from the table memory's single read port.
// A new item is accepted in the cycle its predecessor's result is shown.
// Synchronous reset clears the table (all slots zero) and sets the active count to 1.
// ----------------------------------------------------------------------------
// hdm_decoder_target_lookup
// Host-managed memory decoder table with interleave target selection. Write beats fill
// a decoder slot; lookup beats scan the active slots in order and return the target
// port of the first decoder whose window holds the address, or a miss if uncommitted.
// ----------------------------------------------------------------------------
module hdm_decoder_target_lookup
  import hdmtl_pkg::*;
#(
  parameter int NUM_DECODERS = NumDecodersDef
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire item_t      item,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_wdata,
  output logic            done,
  output result_t         result
);

  localparam int IdxW = (NUM_DECODERS > 1) ? $clog2(NUM_DECODERS) : 1;
  localparam int CntW = $clog2(NUM_DECODERS + 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t            state;
  logic [3:0]        active;
  logic [CntW-1:0]   count;
  logic [IdxW-1:0]   idx;
  logic [63:0]       addr_q;

  logic [CntW-1:0]   count_sat;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  dec_entry_t        wr_data;
  logic [IdxW-1:0]   rd_addr;
  dec_entry_t        entry;
  logic [35:0]       unit;
  logic [35:0]       offset;
  logic              match;
  logic              last;
  logic [63:0]       addr_sh;
  logic [3:0]        way_mask;
  logic [2:0]        port_idx;
  logic [PortW-1:0]  port_sel;

  assign busy = (state == ST_SCAN);

  // Active count, saturated to the number of slots.
  assign count_sat = (6'(active) > 6'(NUM_DECODERS)) ? CntW'(NUM_DECODERS) : CntW'(active);

  // Slot writes are taken only between lookups; writes beyond the table are dropped.
  always_comb begin
    wr_en   = (state == ST_IDLE) && start && (item.mode == ModeWrite) &&
              (5'(item.slot) < 5'(NUM_DECODERS));
    wr_addr = IdxW'(item.slot);
    wr_data = '{base:      item.window_base,
                size:      item.window_size,
                gran:      item.gran_code,
                ways:      item.ways_code,
                committed: item.committed,
                ports:     item.port_list};
  end

  // Slot zero is fetched while idle; during a scan the next slot is fetched.
  assign rd_addr = (state == ST_SCAN) ? IdxW'(idx + IdxW'(1)) : '0;

  hdmtl_table #(
    .NUM_DECODERS (NUM_DECODERS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (entry)
  );

  // Window check of the slot under scan, without wrap-around at the top.
  always_comb begin
    unit   = addr_q[63:UnitShift];
    offset = unit - entry.base;
    match  = (unit >= entry.base) && (offset < entry.size);
    last   = (CntW'(idx) + CntW'(1)) == count;
  end

  // Interleave way select and the port number it picks.
  always_comb begin
    addr_sh  = addr_q >> (7'(GranBaseShift) + 7'(entry.gran));
    way_mask = (4'd1 << entry.ways) - 4'd1;
    port_idx = addr_sh[2:0] & way_mask[2:0];
    port_sel = entry.ports[port_idx*PortW +: PortW];
  end

  // Sequencer with the registered result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      done   <= 1'b0;
      active <= ActiveReset;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        active <= cfg_wdata;
      end
      unique case (state)
        ST_IDLE: begin
          if (start && (item.mode == ModeLookup)) begin
            addr_q <= item.address;
            idx    <= '0;
            count  <= count_sat;
            if (count_sat == '0) begin
              done   <= 1'b1;
              result <= '0;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (match) begin
            done               <= 1'b1;
            result.hit         <= entry.committed;
            result.target_port <= entry.committed ? port_sel : '0;
            state              <= ST_IDLE;
          end else if (last) begin
            done   <= 1'b1;
            result <= '0;
            state  <= ST_IDLE;
          end else begin
            idx <= idx + IdxW'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hdmtl_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hdmtl_table
// Decoder slot memory with one write port and one registered read port.
// Per-slot valid bits are cleared by reset; a slot that was never written
// reads back as all zero, which is the cleared decoder.
// ----------------------------------------------------------------------------
module hdmtl_table
  import hdmtl_pkg::*;
#(
  parameter int NUM_DECODERS = NumDecodersDef,
  localparam int IdxW = (NUM_DECODERS > 1) ? $clog2(NUM_DECODERS) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire logic [IdxW-1:0] wr_addr,
  input  wire dec_entry_t      wr_data,
  input  wire logic [IdxW-1:0] rd_addr,
  output dec_entry_t           rd_data
);

  localparam int Depth = 1 << IdxW;

  dec_entry_t             mem [Depth];
  logic       [Depth-1:0] valid;
  dec_entry_t             rd_raw;
  logic                   rd_valid;

  // Storage array, written and read once per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_raw <= mem[rd_addr];
  end

  // Valid bits stand in for clearing the array at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

  // An unwritten slot looks like a decoder of size zero.
  assign rd_data = rd_valid ? rd_raw : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/hdmtl_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hdmtl_checker
// Port-level checks on the decoder lookup: when result beats may appear and
// what a miss looks like. Bound to the top level below.
// ----------------------------------------------------------------------------
module hdmtl_checker
  import hdmtl_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    start,
  input wire logic    busy,
  input wire item_t   item,
  input wire logic    done,
  input wire result_t result
);

  // A miss always reports port zero.
  a_miss_port_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.hit |-> result.target_port == '0)
    else $error("miss beat carries a nonzero port");

  // A decoder write never produces a result beat.
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (item.mode == ModeWrite) |=> !done)
    else $error("result beat after a decoder write");

  // An accepted lookup either scans or answers at once.
  a_lookup_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (item.mode == ModeLookup) |=> busy || done)
    else $error("lookup accepted but neither scanning nor answered");

  // A result beat is shown only once the block is idle again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while still busy");

  // A scan that ends without a beat is a lost result.
  a_scan_ends_with_beat: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("scan ended without a result beat");

endmodule

bind hdm_decoder_target_lookup hdmtl_checker u_checker (.*);

`default_nettype wire
